// ----- hw/rtl/gs_pkg.sv -----
// ----------------------------------------------------------------------------
// gs_pkg
// Shared types and constants of the Gray-Scott strip engine.
// ----------------------------------------------------------------------------
package gs_pkg;

  // default sizing
  localparam int unsigned CELLS_DEF     = 256;
  localparam int unsigned FRAC_BITS_DEF = 14;

  // fixed channel field widths
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned IDX_W        = 8;
  localparam int unsigned SPEED_W      = 8;
  localparam int unsigned SPEED_LEVELS = 2 ** SPEED_W;

  localparam logic [SPEED_W-1:0] SPEED_RESET   = SPEED_W'(50);
  // speed/50 > 0.55 runs two iterations per advance
  localparam logic [SPEED_W-1:0] TWO_PASS_MIN  = SPEED_W'(28);

  // model coefficients in thousandths
  localparam int unsigned MILLI         = 1000;
  localparam int unsigned F_MILLI       = 38;
  localparam int unsigned KF_MILLI      = 101;
  localparam int unsigned DT_BASE_MILLI = 900;
  localparam int unsigned DT_STEP_MILLI = 12;

  // seeded band spans center +/- BAND_HALF cells
  localparam int unsigned BAND_HALF = 6;

  typedef enum logic [REQ_W-1:0] {
    REQ_SEED    = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_READ    = 2'd2
  } req_code_t;

endpackage

// ----- hw/rtl/gs_channels.sv -----
// ----------------------------------------------------------------------------
// gs_channels
// Valid/ready channel interfaces: request, result and speed write.
// ----------------------------------------------------------------------------
interface gs_req_if import gs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [IDX_W-1:0] cell_index;

  modport source (output valid, req_type, cell_index, input ready);
  modport sink   (input valid, req_type, cell_index, output ready);
endinterface

interface gs_res_if import gs_pkg::*; #(
  parameter int unsigned VW = FRAC_BITS_DEF + 1
) ();
  logic          valid;
  logic          ready;
  logic [VW-1:0] u_level;
  logic [VW-1:0] v_level;

  modport source (output valid, u_level, v_level, input ready);
  modport sink   (input valid, u_level, v_level, output ready);
endinterface

interface gs_cfg_if import gs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed;

  modport source (output valid, speed, input ready);
  modport sink   (input valid, speed, output ready);
endinterface

// ----- hw/rtl/gs_ram.sv -----
// ----------------------------------------------------------------------------
// gs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gs_ram import gs_pkg::*; #(
  parameter int unsigned DEPTH = CELLS_DEF,
  parameter int unsigned W     = FRAC_BITS_DEF + 1,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/gs_cell_pe.sv -----
// ----------------------------------------------------------------------------
// gs_cell_pe
// Four-stage pipeline that updates one cell per cycle from its 3-cell window.
// ----------------------------------------------------------------------------
module gs_cell_pe import gs_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned AW        = $clog2(CELLS_DEF),
  localparam int unsigned VW       = FRAC_BITS + 1,
  localparam int unsigned DTW      = FRAC_BITS + 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [AW-1:0]  in_addr,
  input  logic [VW-1:0]  u_lo,
  input  logic [VW-1:0]  u_mid,
  input  logic [VW-1:0]  u_hi,
  input  logic [VW-1:0]  v_lo,
  input  logic [VW-1:0]  v_mid,
  input  logic [VW-1:0]  v_hi,
  input  logic [DTW-1:0] dt,
  output logic           wr_en,
  output logic [AW-1:0]  wr_addr,
  output logic [VW-1:0]  wr_u,
  output logic [VW-1:0]  wr_v,
  output logic           busy
);

  localparam int unsigned LW = FRAC_BITS + 3;        // laplacian
  localparam int unsigned PW = 2 * VW;               // unsigned products
  localparam int unsigned DW = FRAC_BITS + 4;        // du, dv
  localparam int unsigned MW = DW + DTW + 1;         // du * dt
  localparam longint ONE     = longint'(1) <<< FRAC_BITS;
  localparam longint F_FX    = ((longint'(F_MILLI) <<< FRAC_BITS) + MILLI / 2) / MILLI;
  localparam longint KF_FX   = ((longint'(KF_MILLI) <<< FRAC_BITS) + MILLI / 2) / MILLI;
  localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
  localparam logic [MW-1:0] HALF_M = MW'(1) << (FRAC_BITS - 1);

  typedef logic signed [MW-1:0] m_t;

  // round to nearest, halves away from zero
  function automatic m_t rnd_m(m_t x);
    logic [MW-1:0] mag;
    logic [MW-1:0] r;
    mag = x[MW-1] ? MW'(-x) : MW'(x);
    r   = (mag + HALF_M) >> FRAC_BITS;
    return x[MW-1] ? m_t'(-r) : m_t'(r);
  endfunction

  // stage 1
  logic                 s1_valid;
  logic [AW-1:0]        s1_addr;
  logic [VW-1:0]        s1_u, s1_v;
  logic signed [LW-1:0] s1_lapu, s1_lapvh;
  logic [PW-1:0]        s1_puv, s1_pf, s1_pk;
  // stage 2
  logic                 s2_valid;
  logic [AW-1:0]        s2_addr;
  logic [VW-1:0]        s2_u, s2_v, s2_fu, s2_kv;
  logic signed [LW-1:0] s2_lapu, s2_lapvh;
  logic [PW-1:0]        s2_a;
  // stage 3
  logic                 s3_valid;
  logic [AW-1:0]        s3_addr;
  logic [VW-1:0]        s3_u, s3_v;
  logic signed [DW-1:0] s3_du, s3_dv;
  // stage 4
  logic                 s4_valid;
  logic [AW-1:0]        s4_addr;
  logic [VW-1:0]        s4_u, s4_v;
  logic signed [MW-1:0] s4_mu, s4_mv;

  logic signed [LW-1:0] lap_u, lap_v, lap_v_mag, lap_v_half;
  logic [VW-1:0]        r_uv, uvv;
  m_t                   sum_u, sum_v;

  assign lap_u = LW'(u_lo) + LW'(u_hi) - (LW'(u_mid) << 1);
  assign lap_v = LW'(v_lo) + LW'(v_hi) - (LW'(v_mid) << 1);
  assign lap_v_mag  = lap_v[LW-1] ? -lap_v : lap_v;
  assign lap_v_half = lap_v[LW-1] ? -((lap_v_mag + LW'(1)) >>> 1)
                                  : ((lap_v_mag + LW'(1)) >>> 1);

  assign r_uv = VW'((s1_puv + HALF_P) >> FRAC_BITS);
  assign uvv  = VW'((s2_a + HALF_P) >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
    // products and laplacians
    s1_addr  <= in_addr;
    s1_u     <= u_mid;
    s1_v     <= v_mid;
    s1_lapu  <= lap_u;
    s1_lapvh <= lap_v_half;
    s1_puv   <= PW'(u_mid) * PW'(v_mid);
    s1_pf    <= PW'(F_FX) * PW'(VW'(ONE) - u_mid);
    s1_pk    <= PW'(KF_FX) * PW'(v_mid);
    // second factor of u*v*v
    s2_addr  <= s1_addr;
    s2_u     <= s1_u;
    s2_v     <= s1_v;
    s2_lapu  <= s1_lapu;
    s2_lapvh <= s1_lapvh;
    s2_a     <= PW'(r_uv) * PW'(s1_v);
    s2_fu    <= VW'((s1_pf + HALF_P) >> FRAC_BITS);
    s2_kv    <= VW'((s1_pk + HALF_P) >> FRAC_BITS);
    // rates of change
    s3_addr  <= s2_addr;
    s3_u     <= s2_u;
    s3_v     <= s2_v;
    s3_du    <= DW'(s2_lapu) - DW'(uvv) + DW'(s2_fu);
    s3_dv    <= DW'(s2_lapvh) + DW'(uvv) - DW'(s2_kv);
    // scale by time step
    s4_addr  <= s3_addr;
    s4_u     <= s3_u;
    s4_v     <= s3_v;
    s4_mu    <= MW'(s3_du) * MW'(signed'({1'b0, dt}));
    s4_mv    <= MW'(s3_dv) * MW'(signed'({1'b0, dt}));
  end

  assign sum_u = m_t'(MW'(s4_u)) + rnd_m(s4_mu);
  assign sum_v = m_t'(MW'(s4_v)) + rnd_m(s4_mv);

  // saturate to 0 .. 1.0
  always_comb begin
    if (sum_u < 0) begin
      wr_u = '0;
    end else if (sum_u > m_t'(ONE)) begin
      wr_u = VW'(ONE);
    end else begin
      wr_u = VW'(sum_u);
    end
    if (sum_v < 0) begin
      wr_v = '0;
    end else if (sum_v > m_t'(ONE)) begin
      wr_v = VW'(ONE);
    end else begin
      wr_v = VW'(sum_v);
    end
  end

  assign wr_en   = s4_valid;
  assign wr_addr = s4_addr;
  assign busy    = s1_valid | s2_valid | s3_valid | s4_valid;

endmodule

// ----- hw/rtl/gray_scott_1d_step_unit.sv -----
// ----------------------------------------------------------------------------
// gray_scott_1d_step_unit
// 1-D Gray-Scott reaction-diffusion strip held in two on-chip RAMs.
// ----------------------------------------------------------------------------
// Advance: one sweep pass when speed < 28, two otherwise.
// Throughput: one item at a time; the sweep moves one cell per cycle, bound
//   by the single read port of each RAM.
// Reset: speed returns to 50 and a seeding sweep rewrites both RAMs;
//   req.ready stays low until it is done. No result is produced.
// ----------------------------------------------------------------------------
module gray_scott_1d_step_unit import gs_pkg::*; #(
  parameter int unsigned CELLS     = CELLS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input logic    clk,
  input logic    rst,
  gs_cfg_if.sink cfg,
  gs_req_if.sink req,
  gs_res_if.source res
);

  localparam int unsigned AW  = $clog2(CELLS);
  localparam int unsigned VW  = FRAC_BITS + 1;
  localparam int unsigned DTW = FRAC_BITS + 2;
  localparam int unsigned SW  = $clog2(CELLS + 2);
  localparam int unsigned IXW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int unsigned MID = CELLS / 2;

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] BAND_LO   = AW'(MID - BAND_HALF);
  localparam logic [AW-1:0] BAND_HI   = AW'(MID + BAND_HALF);
  localparam logic [SW-1:0] STEP_LAST = SW'(CELLS + 1);
  localparam logic [VW-1:0] ONE_VAL   = VW'(1) << FRAC_BITS;

  // time step per speed setting: round((900 + 12*speed) * ONE / 1000)
  typedef logic [DTW-1:0] dt_tab_t [SPEED_LEVELS];

  function automatic dt_tab_t build_dt_tab();
    dt_tab_t t;
    for (int s = 0; s < SPEED_LEVELS; s++) begin
      t[s] = DTW'(((longint'(DT_BASE_MILLI + DT_STEP_MILLI * s) <<< FRAC_BITS)
                   + MILLI / 2) / MILLI);
    end
    return t;
  endfunction

  localparam dt_tab_t DT_TAB = build_dt_tab();

  typedef enum logic [2:0] {
    ST_SEED,
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t             state;
  logic [SPEED_W-1:0] speed;
  logic [DTW-1:0]     dt;
  logic               two_pass;
  logic               seed_reply;
  logic [AW-1:0]      seed_cnt;
  logic [SW-1:0]      step;
  logic               rd_oob;
  logic [VW-1:0]      pend_u, pend_v;
  logic               res_valid;
  logic [VW-1:0]      res_u, res_v;

  // sweep read pipeline and 3-cell window
  logic               rd_valid;
  logic [SW-1:0]      rd_step;
  logic               win_valid;
  logic [AW-1:0]      win_addr;
  logic [VW-1:0]      wu0, wu1, wu2, wv0, wv1, wv2;

  // RAM ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr, sweep_addr;
  logic [VW-1:0]      ram_wu, ram_wv, ram_qu, ram_qv;

  // pipeline write-back
  logic               pe_we, pe_busy;
  logic [AW-1:0]      pe_addr;
  logic [VW-1:0]      pe_u, pe_v;

  logic [IXW-1:0]     idx_ext;
  logic               in_band;

  assign idx_ext = IXW'(req.cell_index);
  assign in_band = (seed_cnt >= BAND_LO) && (seed_cnt <= BAND_HI);

  // sweep order: cell 0, cells 0 .. CELLS-1, last cell again (clamped edges)
  always_comb begin
    if (step == '0) begin
      sweep_addr = '0;
    end else if (step == STEP_LAST) begin
      sweep_addr = LAST_CELL;
    end else begin
      sweep_addr = AW'(step - SW'(1));
    end
  end

  assign ram_raddr = (state == ST_IDLE) ? AW'(idx_ext) : sweep_addr;

  // seeding writes and pipeline write-back never overlap
  assign ram_we    = (state == ST_SEED) | pe_we;
  assign ram_waddr = (state == ST_SEED) ? seed_cnt : pe_addr;
  assign ram_wu    = (state == ST_SEED) ? (in_band ? '0 : ONE_VAL) : pe_u;
  assign ram_wv    = (state == ST_SEED) ? (in_band ? ONE_VAL : '0) : pe_v;

  gs_ram #(.DEPTH(CELLS), .W(VW)) u_ram_u (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wu),
    .raddr (ram_raddr),
    .rdata (ram_qu)
  );

  gs_ram #(.DEPTH(CELLS), .W(VW)) u_ram_v (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wv),
    .raddr (ram_raddr),
    .rdata (ram_qv)
  );

  // Control: one clocked block for state, counters and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SEED;
      speed      <= SPEED_RESET;
      seed_cnt   <= '0;
      seed_reply <= 1'b0;
      two_pass   <= 1'b0;
      step       <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        speed <= cfg.speed;
      end
      // drop the result once taken; ST_DONE handles its own load below
      if (res_valid && res.ready && (state != ST_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_SEED: begin
          seed_cnt <= seed_cnt + AW'(1);
          if (seed_cnt == LAST_CELL) begin
            pend_u <= '0;
            pend_v <= '0;
            state  <= seed_reply ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            case (req.req_type)
              REQ_SEED: begin
                seed_cnt   <= '0;
                seed_reply <= 1'b1;
                state      <= ST_SEED;
              end
              REQ_ADVANCE: begin
                dt       <= DT_TAB[speed];
                two_pass <= (speed >= TWO_PASS_MIN);
                step     <= '0;
                state    <= ST_SWEEP;
              end
              REQ_READ: begin
                // RAM captures the address at this edge
                rd_oob <= (idx_ext >= IXW'(CELLS));
                state  <= ST_READ;
              end
              default: begin
                pend_u <= '0;
                pend_v <= '0;
                state  <= ST_DONE;
              end
            endcase
          end
        end
        ST_READ: begin
          pend_u <= rd_oob ? '0 : ram_qu;
          pend_v <= rd_oob ? '0 : ram_qv;
          state  <= ST_DONE;
        end
        ST_SWEEP: begin
          step <= step + SW'(1);
          if (step == STEP_LAST) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // hold until every write of this pass has landed
          if (!rd_valid && !win_valid && !pe_busy) begin
            if (two_pass) begin
              two_pass <= 1'b0;
              step     <= '0;
              state    <= ST_SWEEP;
            end else begin
              pend_u <= '0;
              pend_v <= '0;
              state  <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_u     <= pend_u;
            res_v     <= pend_v;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Window: each returned word shifts in; after the third the center cell
  // (step - 2) is complete and goes to the pipeline. The write of a cell
  // lands only after the read of its right neighbor, so the update runs in
  // place and still sees the old values.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      win_valid <= 1'b0;
    end else begin
      rd_valid  <= (state == ST_SWEEP);
      win_valid <= rd_valid && (rd_step >= SW'(2));
    end
    rd_step  <= step;
    win_addr <= AW'(rd_step - SW'(2));
    if (rd_valid) begin
      wu0 <= wu1;
      wu1 <= wu2;
      wu2 <= ram_qu;
      wv0 <= wv1;
      wv1 <= wv2;
      wv2 <= ram_qv;
    end
  end

  gs_cell_pe #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_pe (
    .clk      (clk),
    .rst      (rst),
    .in_valid (win_valid),
    .in_addr  (win_addr),
    .u_lo     (wu0),
    .u_mid    (wu1),
    .u_hi     (wu2),
    .v_lo     (wv0),
    .v_mid    (wv1),
    .v_hi     (wv2),
    .dt       (dt),
    .wr_en    (pe_we),
    .wr_addr  (pe_addr),
    .wr_u     (pe_u),
    .wr_v     (pe_v),
    .busy     (pe_busy)
  );

  assign cfg.ready   = 1'b1;
  assign req.ready   = (state == ST_IDLE);
  assign res.valid   = res_valid;
  assign res.u_level = res_u;
  assign res.v_level = res_v;

endmodule

// ----- hw/rtl/gs_checker.sv -----
// ----------------------------------------------------------------------------
// gs_checker
// Port-level checks on the strip engine, bound to the top level.
// ----------------------------------------------------------------------------
module gs_checker import gs_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned VW       = FRAC_BITS + 1
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          res_valid,
  input logic          res_ready,
  input logic [VW-1:0] u_level,
  input logic [VW-1:0] v_level
);

  localparam logic [VW-1:0] ONE_VAL = VW'(1) << FRAC_BITS;

  // items accepted whose result is not yet taken
  logic [1:0] open_items;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_items <= '0;
    end else begin
      open_items <= open_items + 2'((req_valid && req_ready) ? 1 : 0)
                               - 2'((res_valid && res_ready) ? 1 : 0);
    end
  end

  a_seed_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken during the seeding sweep after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(u_level) && $stable(v_level))
    else $error("stalled result changed or vanished");

  a_levels_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (u_level <= ONE_VAL) && (v_level <= ONE_VAL))
    else $error("concentration above 1.0");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> open_items != 2'd0)
    else $error("result without an open item");

  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    open_items != 2'd3)
    else $error("more than two items open");

endmodule

bind gray_scott_1d_step_unit gs_checker #(.FRAC_BITS(FRAC_BITS)) u_gs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .u_level   (res.u_level),
  .v_level   (res.v_level)
);
